FILE: hdl/lav_pkg.sv
package lav_pkg;

    // Field and datapath widths
    localparam int CoordW     = 32;
    localparam int OpW        = 33;   // multiplier operand, Q30 unit components
    localparam int ProdW      = 2 * OpW;
    localparam int AccW       = ProdW + 2;
    localparam int SqW        = 64;   // squared lengths
    localparam int NumW       = 96;   // shifted dividend
    localparam int QuotW      = 33;
    localparam int QueueDepth = 2;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [OpW-1:0]    q30_t;

    // One classified item as the front end hands it over
    typedef struct packed {
        logic [CoordW-1:0] mag_x;
        logic [CoordW-1:0] mag_y;
        logic [CoordW-1:0] mag_z;
        logic              neg_x;
        logic              neg_y;
        logic              neg_z;
        coord_t            eye_x;
        coord_t            eye_y;
        coord_t            eye_z;
        logic              degen;
    } lav_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_WB,
        ST_NORM,
        ST_SQRT,
        ST_DSET,
        ST_DIV,
        ST_EMIT
    } back_state_t;

    typedef enum logic [3:0] {
        WB_NONE,
        WB_H2,
        WB_L2,
        WB_U0,
        WB_U1,
        WB_U2,
        WB_T0,
        WB_T1,
        WB_T2
    } wb_sel_t;

endpackage

FILE: hdl/lav_front.sv
module lav_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  lav_pkg::coord_t     eye_x,
    input  lav_pkg::coord_t     eye_y,
    input  lav_pkg::coord_t     eye_z,
    input  lav_pkg::coord_t     target_x,
    input  lav_pkg::coord_t     target_y,
    input  lav_pkg::coord_t     target_z,
    output logic                entry_valid,
    input  logic                entry_ready,
    output lav_pkg::lav_entry_t entry
);
    import lav_pkg::*;

    logic signed [CoordW:0] dx, dy, dz;
    logic [CoordW:0]        ax, ay, az;
    logic [CoordW:0]        hx, hy, hz;
    logic                   big;
    lav_entry_t             entry_reg, entry_next;
    logic                   valid_reg;

    // Difference vector and its magnitudes
    assign dx = {target_x[CoordW-1], target_x} - {eye_x[CoordW-1], eye_x};
    assign dy = {target_y[CoordW-1], target_y} - {eye_y[CoordW-1], eye_y};
    assign dz = {target_z[CoordW-1], target_z} - {eye_z[CoordW-1], eye_z};
    assign ax = dx[CoordW] ? (CoordW+1)'(-dx) : (CoordW+1)'(dx);
    assign ay = dy[CoordW] ? (CoordW+1)'(-dy) : (CoordW+1)'(dy);
    assign az = dz[CoordW] ? (CoordW+1)'(-dz) : (CoordW+1)'(dz);

    // Halve everything, rounding up, when any magnitude reaches 2^31
    assign big = |{ax[CoordW:CoordW-1], ay[CoordW:CoordW-1], az[CoordW:CoordW-1]};
    assign hx  = ax + (CoordW+1)'(1);
    assign hy  = ay + (CoordW+1)'(1);
    assign hz  = az + (CoordW+1)'(1);

    always_comb
    begin
        entry_next.mag_x = big ? hx[CoordW:1] : ax[CoordW-1:0];
        entry_next.mag_y = big ? hy[CoordW:1] : ay[CoordW-1:0];
        entry_next.mag_z = big ? hz[CoordW:1] : az[CoordW-1:0];
        entry_next.neg_x = dx[CoordW];
        entry_next.neg_y = dy[CoordW];
        entry_next.neg_z = dz[CoordW];
        entry_next.eye_x = eye_x;
        entry_next.eye_y = eye_y;
        entry_next.eye_z = eye_z;
        entry_next.degen = (dx == '0) && (dy == '0);
    end

    assign item_ready  = !valid_reg || entry_ready;
    assign entry_valid = valid_reg;
    assign entry       = entry_reg;

    // Output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

FILE: hdl/lav_queue.sv
module lav_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  lav_pkg::lav_entry_t push_entry,
    output logic                pop_valid,
    input  logic                pop_ready,
    output lav_pkg::lav_entry_t pop_entry
);
    import lav_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    lav_entry_t        mem [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]   count_reg;
    logic              push, pop;

    assign push_ready = (count_reg != CntW'(QueueDepth));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = mem[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : wr_ptr_reg + PtrW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0
                                                                   : rd_ptr_reg + PtrW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CntW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CntW'(1);
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hdl/lav_back.sv
module lav_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                entry_valid,
    output logic                entry_ready,
    input  lav_pkg::lav_entry_t entry,
    output logic                column_valid,
    input  logic                column_ready,
    output logic [1:0]          column_index,
    output lav_pkg::coord_t     row0_value,
    output lav_pkg::coord_t     row1_value,
    output lav_pkg::coord_t     row2_value,
    output logic                last_column,
    output logic                degenerate
);
    import lav_pkg::*;

    localparam int RndW = AccW - 29;    // magnitude after dropping 30 fraction bits
    localparam int KW   = 5;
    localparam int OpIdxW = 4;
    localparam logic [OpIdxW-1:0] OpFirstMac = OpIdxW'(3);
    localparam logic [KW-1:0]     KMax       = KW'(31);

    // Round half away from zero by 14 bits (Q30 to Q16)
    function automatic coord_t rnd14(input q30_t v);
        logic [OpW-1:0] mag;
        logic [OpW-1:0] sum;
        mag = v[OpW-1] ? OpW'(-v) : OpW'(v);
        sum = mag + OpW'(1 << 13);
        return v[OpW-1] ? -coord_t'(sum[OpW-1:14]) : coord_t'(sum[OpW-1:14]);
    endfunction

    // Round half away from zero by 30 bits, optional negate
    function automatic logic signed [RndW:0] rnd30(input logic signed [AccW-1:0] v,
                                                   input logic neg);
        logic [AccW-1:0] mag;
        logic [AccW-1:0] sum;
        logic [RndW:0]   m;
        mag = v[AccW-1] ? AccW'(-v) : AccW'(v);
        sum = mag + AccW'(1 << 29);
        m   = (RndW+1)'(sum[AccW-1:30]);
        return (v[AccW-1] ^ neg) ? -$signed(m) : $signed(m);
    endfunction

    function automatic coord_t sat32(input logic signed [RndW:0] v);
        if (v > $signed((RndW+1)'(32'h7fff_ffff)))
        begin
            return coord_t'(32'h7fff_ffff);
        end
        else if (v < -$signed((RndW+1)'(32'h8000_0000)))
        begin
            return coord_t'(32'h8000_0000);
        end
        return coord_t'(v[CoordW-1:0]);
    endfunction

    back_state_t             state_reg, state_next;
    lav_entry_t              ent_reg;
    logic [OpIdxW-1:0]       op_reg;
    logic signed [ProdW-1:0] prod_reg;
    logic signed [AccW-1:0]  acc_reg;
    logic [SqW-1:0]          h2_reg, l2_reg;
    logic [CoordW-1:0]       sh_reg, sl_reg;
    logic [KW-1:0]           kh_reg, kl_reg;
    logic                    job_l_reg;
    logic [SqW-1:0]          v_reg;
    logic [KW-1:0]           k_reg;
    logic [SqW:0]            r_reg;
    logic [SqW-1:0]          bit_reg;
    logic [2:0]              div_idx_reg;
    logic [CoordW-1:0]       dvs_reg;
    logic [CoordW-1:0]       rem_reg;
    logic [QuotW-1:0]        num_reg;
    logic [QuotW-1:0]        quo_reg;
    logic [5:0]              cnt_reg;
    q30_t                    f0_reg, f1_reg, f2_reg, r0_reg, r1_reg;
    q30_t                    u0_reg, u1_reg, u2_reg;
    coord_t                  t0_reg, t1_reg, t2_reg;
    logic [1:0]              col_reg;
    logic                    out_valid_reg;
    logic [1:0]              out_col_reg;
    coord_t                  out_r0_reg, out_r1_reg, out_r2_reg;
    logic                    out_degen_reg;

    // Operation decode
    q30_t                    opa, opb;
    logic                    op_clr, op_sub, op_neg;
    wb_sel_t                 op_wb;
    logic signed [ProdW-1:0] prod_c;
    q30_t                    ex_q, ey_q, ez_q, mx_q, my_q, mz_q;

    assign ex_q = {ent_reg.eye_x[CoordW-1], ent_reg.eye_x};
    assign ey_q = {ent_reg.eye_y[CoordW-1], ent_reg.eye_y};
    assign ez_q = {ent_reg.eye_z[CoordW-1], ent_reg.eye_z};
    assign mx_q = $signed({1'b0, ent_reg.mag_x});
    assign my_q = $signed({1'b0, ent_reg.mag_y});
    assign mz_q = $signed({1'b0, ent_reg.mag_z});

    always_comb
    begin
        opa    = mx_q;
        opb    = mx_q;
        op_clr = 1'b0;
        op_sub = 1'b0;
        op_neg = 1'b0;
        op_wb  = WB_NONE;
        case (op_reg)
            4'd0:  begin opa = mx_q;   opb = mx_q; op_clr = 1'b1;                   end
            4'd1:  begin opa = my_q;   opb = my_q; op_wb = WB_H2;                   end
            4'd2:  begin opa = mz_q;   opb = mz_q; op_wb = WB_L2;                   end
            4'd3:  begin opa = r1_reg; opb = f2_reg; op_clr = 1'b1; op_wb = WB_U0;  end
            4'd4:  begin opa = r0_reg; opb = f2_reg; op_clr = 1'b1; op_neg = 1'b1;
                         op_wb = WB_U1;                                             end
            4'd5:  begin opa = r0_reg; opb = f1_reg; op_clr = 1'b1;                 end
            4'd6:  begin opa = r1_reg; opb = f0_reg; op_sub = 1'b1; op_wb = WB_U2;  end
            4'd7:  begin opa = r0_reg; opb = ex_q; op_clr = 1'b1;                   end
            4'd8:  begin opa = r1_reg; opb = ey_q; op_neg = 1'b1; op_wb = WB_T0;    end
            4'd9:  begin opa = u0_reg; opb = ex_q; op_clr = 1'b1;                   end
            4'd10: begin opa = u1_reg; opb = ey_q;                                  end
            4'd11: begin opa = u2_reg; opb = ez_q; op_neg = 1'b1; op_wb = WB_T1;    end
            4'd12: begin opa = f0_reg; opb = ex_q; op_clr = 1'b1;                   end
            4'd13: begin opa = f1_reg; opb = ey_q;                                  end
            4'd14: begin opa = f2_reg; opb = ez_q; op_wb = WB_T2;                   end
            default: begin opa = mx_q; opb = mx_q;                                  end
        endcase
    end

    assign prod_c = opa * opb;

    // Accumulate
    logic signed [AccW-1:0] prod_ext, acc_base, acc_sum;
    assign prod_ext = {{(AccW-ProdW){prod_reg[ProdW-1]}}, prod_reg};
    assign acc_base = op_clr ? '0 : acc_reg;
    assign acc_sum  = op_sub ? acc_base - prod_ext : acc_base + prod_ext;

    logic signed [RndW:0] rnd_acc;
    assign rnd_acc = rnd30(acc_reg, op_neg);

    // Root step
    logic [SqW:0]   r_bit;
    logic [SqW:0]   r_next;
    logic [SqW-1:0] v_next;
    logic           r_take;
    assign r_bit  = r_reg + {1'b0, bit_reg};
    assign r_take = ({1'b0, v_reg} >= r_bit);
    assign v_next = r_take ? v_reg - r_bit[SqW-1:0] : v_reg;
    assign r_next = r_take ? (r_reg >> 1) + {1'b0, bit_reg} : (r_reg >> 1);

    // Divider setup and step
    logic [CoordW-1:0] dset_m, dset_s;
    logic [KW-1:0]     dset_k;
    logic [NumW-1:0]   dset_num;
    always_comb
    begin
        dset_m = ent_reg.mag_x;
        dset_s = sl_reg;
        dset_k = kl_reg;
        case (div_idx_reg)
            3'd0:    begin dset_m = ent_reg.mag_x; dset_s = sl_reg; dset_k = kl_reg; end
            3'd1:    begin dset_m = ent_reg.mag_y; dset_s = sl_reg; dset_k = kl_reg; end
            3'd2:    begin dset_m = ent_reg.mag_z; dset_s = sl_reg; dset_k = kl_reg; end
            3'd3:    begin dset_m = ent_reg.mag_y; dset_s = sh_reg; dset_k = kh_reg; end
            3'd4:    begin dset_m = ent_reg.mag_x; dset_s = sh_reg; dset_k = kh_reg; end
            default: begin dset_m = ent_reg.mag_x; dset_s = sl_reg; dset_k = kl_reg; end
        endcase
    end
    assign dset_num = (NumW'(dset_m) << (7'd30 + 7'(dset_k))) + NumW'(dset_s >> 1);

    logic [CoordW:0]    rem_sh;
    logic               q_bit;
    logic [CoordW-1:0]  rem_next;
    logic [QuotW-1:0]   quo_next;
    q30_t               q_pos;
    assign rem_sh   = {rem_reg, num_reg[QuotW-1]};
    assign q_bit    = (rem_sh >= {1'b0, dvs_reg});
    assign rem_next = q_bit ? CoordW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CoordW-1:0];
    assign quo_next = {quo_reg[QuotW-2:0], q_bit};
    assign q_pos    = $signed(quo_next);

    // Column values
    coord_t col_r0, col_r1, col_r2;
    logic   emit_load;
    always_comb
    begin
        col_r0 = '0;
        col_r1 = '0;
        col_r2 = '0;
        case (col_reg)
            2'd0:    begin col_r0 = rnd14(r0_reg); col_r1 = rnd14(u0_reg);
                           col_r2 = -rnd14(f0_reg); end
            2'd1:    begin col_r0 = rnd14(r1_reg); col_r1 = rnd14(u1_reg);
                           col_r2 = -rnd14(f1_reg); end
            2'd2:    begin col_r0 = '0;            col_r1 = rnd14(u2_reg);
                           col_r2 = -rnd14(f2_reg); end
            default: begin col_r0 = t0_reg; col_r1 = t1_reg; col_r2 = t2_reg; end
        endcase
        if (ent_reg.degen)
        begin
            col_r0 = '0;
            col_r1 = '0;
            col_r2 = '0;
        end
    end

    assign emit_load   = (state_reg == ST_EMIT) && (!out_valid_reg || column_ready);
    assign entry_ready = (state_reg == ST_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (entry_valid) state_next = entry.degen ? ST_EMIT : ST_MUL;
            ST_MUL:  state_next = ST_ACC;
            ST_ACC:  state_next = (op_wb == WB_NONE) ? ST_MUL : ST_WB;
            ST_WB:
            begin
                case (op_wb)
                    WB_L2:   state_next = ST_NORM;
                    WB_T2:   state_next = ST_EMIT;
                    default: state_next = ST_MUL;
                endcase
            end
            ST_NORM: if (v_reg[SqW-1:SqW-2] != 2'b00 || k_reg == KMax) state_next = ST_SQRT;
            ST_SQRT: if (bit_reg[0]) state_next = job_l_reg ? ST_DSET : ST_NORM;
            ST_DSET: state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == 6'(QuotW - 1))
                begin
                    state_next = (div_idx_reg == 3'd4) ? ST_MUL : ST_DSET;
                end
            end
            ST_EMIT: if (emit_load && col_reg == 2'd3) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (entry_valid)
                begin
                    ent_reg <= entry;
                    op_reg  <= '0;
                    col_reg <= '0;
                end
            end
            ST_MUL:
            begin
                prod_reg <= prod_c;
            end
            ST_ACC:
            begin
                acc_reg <= acc_sum;
                if (op_wb == WB_NONE)
                begin
                    op_reg <= op_reg + OpIdxW'(1);
                end
            end
            ST_WB:
            begin
                op_reg <= op_reg + OpIdxW'(1);
                case (op_wb)
                    WB_H2: h2_reg <= acc_reg[SqW-1:0];
                    WB_L2:
                    begin
                        l2_reg    <= acc_reg[SqW-1:0];
                        v_reg     <= h2_reg;
                        k_reg     <= '0;
                        job_l_reg <= 1'b0;
                    end
                    WB_U0: u0_reg <= q30_t'(rnd_acc);
                    WB_U1: u1_reg <= q30_t'(rnd_acc);
                    WB_U2: u2_reg <= q30_t'(rnd_acc);
                    WB_T0: t0_reg <= sat32(rnd_acc);
                    WB_T1: t1_reg <= sat32(rnd_acc);
                    WB_T2:
                    begin
                        t2_reg  <= sat32(rnd_acc);
                        col_reg <= '0;
                    end
                    default: ;
                endcase
            end
            ST_NORM:
            begin
                if (v_reg[SqW-1:SqW-2] == 2'b00 && k_reg != KMax)
                begin
                    v_reg <= v_reg << 2;
                    k_reg <= k_reg + KW'(1);
                end
                else
                begin
                    r_reg   <= '0;
                    bit_reg <= SqW'(1) << (SqW - 2);
                end
            end
            ST_SQRT:
            begin
                v_reg   <= v_next;
                r_reg   <= r_next;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    if (job_l_reg)
                    begin
                        sl_reg      <= r_next[CoordW-1:0];
                        kl_reg      <= k_reg;
                        div_idx_reg <= '0;
                    end
                    else
                    begin
                        sh_reg    <= r_next[CoordW-1:0];
                        kh_reg    <= k_reg;
                        v_reg     <= l2_reg;
                        k_reg     <= '0;
                        job_l_reg <= 1'b1;
                    end
                end
            end
            ST_DSET:
            begin
                dvs_reg <= dset_s;
                rem_reg <= dset_num[QuotW+CoordW-1:QuotW];
                num_reg <= dset_num[QuotW-1:0];
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_next;
                num_reg <= num_reg << 1;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(QuotW - 1))
                begin
                    div_idx_reg <= div_idx_reg + 3'd1;
                    op_reg      <= OpFirstMac;
                    case (div_idx_reg)
                        3'd0:    f0_reg <= ent_reg.neg_x ? -q_pos : q_pos;
                        3'd1:    f1_reg <= ent_reg.neg_y ? -q_pos : q_pos;
                        3'd2:    f2_reg <= ent_reg.neg_z ? -q_pos : q_pos;
                        3'd3:    r0_reg <= ent_reg.neg_y ? -q_pos : q_pos;
                        default: r1_reg <= ent_reg.neg_x ? q_pos : -q_pos;
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    col_reg <= col_reg + 2'd1;
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (column_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            out_col_reg   <= col_reg;
            out_r0_reg    <= col_r0;
            out_r1_reg    <= col_r1;
            out_r2_reg    <= col_r2;
            out_degen_reg <= ent_reg.degen;
        end
    end

    assign column_valid = out_valid_reg;
    assign column_index = out_col_reg;
    assign row0_value   = out_r0_reg;
    assign row1_value   = out_r1_reg;
    assign row2_value   = out_r2_reg;
    assign last_column  = (out_col_reg == 2'd3);
    assign degenerate   = out_degen_reg;

endmodule

FILE: hdl/look_at_view_matrix.sv
// Look-at view matrix generator, signed Q16.16 in and out, world up (0,0,1).
// Item channel: item_valid/item_ready carry eye_x..z and target_x..z; one
// transfer is one item. Column channel: column_valid/column_ready carry four
// transfers per item, columns 0..3 in order; last_column marks column 3 and
// degenerate marks an item with eye equal to target or a view along up, whose
// row values are then all zero.
// A regular item's time to its first column depends on the normalizing
// shifts ahead of the two square roots; the back end computes both square
// roots one result bit per cycle and the five unit-vector quotients one
// quotient bit per cycle on a single shared divider, and all products on one
// 33x33 multiplier. A degenerate item skips these steps and goes straight to
// the emit step. Throughput: one item per back-end pass; the front end and
// a two-entry queue keep taking items during that pass.
// Reset clears all control state; no clearing pass is needed.
// When the receiver holds column_ready low the output register keeps its
// column, the back end waits in its emit step, and once the queue is full
// item_ready drops.
module look_at_view_matrix (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_ready,
    input  lav_pkg::coord_t eye_x,
    input  lav_pkg::coord_t eye_y,
    input  lav_pkg::coord_t eye_z,
    input  lav_pkg::coord_t target_x,
    input  lav_pkg::coord_t target_y,
    input  lav_pkg::coord_t target_z,
    output logic            column_valid,
    input  logic            column_ready,
    output logic [1:0]      column_index,
    output lav_pkg::coord_t row0_value,
    output lav_pkg::coord_t row1_value,
    output lav_pkg::coord_t row2_value,
    output logic            last_column,
    output logic            degenerate
);
    import lav_pkg::*;

    lav_entry_t front_entry, queue_entry;
    logic       front_valid, front_ready;
    logic       queue_valid, queue_ready;

    lav_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .eye_x       (eye_x),
        .eye_y       (eye_y),
        .eye_z       (eye_z),
        .target_x    (target_x),
        .target_y    (target_y),
        .target_z    (target_z),
        .entry_valid (front_valid),
        .entry_ready (front_ready),
        .entry       (front_entry)
    );

    lav_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_entry (front_entry),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_entry  (queue_entry)
    );

    lav_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (queue_valid),
        .entry_ready  (queue_ready),
        .entry        (queue_entry),
        .column_valid (column_valid),
        .column_ready (column_ready),
        .column_index (column_index),
        .row0_value   (row0_value),
        .row1_value   (row1_value),
        .row2_value   (row2_value),
        .last_column  (last_column),
        .degenerate   (degenerate)
    );

    // Columns of one item follow each other without gaps once taken
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && column_ready && !last_column |=>
            column_valid && (column_index == $past(column_index) + 2'd1))
        else $error("column sequence broken");

    // A degenerate view carries only zeros
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && degenerate |->
            (row0_value == '0) && (row1_value == '0) && (row2_value == '0))
        else $error("degenerate column with nonzero value");

    // Right vector has no z component
    a_col2_row0: assert property (@(posedge clk) disable iff (!rst_n)
        column_valid && (column_index == 2'd2) |-> (row0_value == '0))
        else $error("column 2 row 0 nonzero");

endmodule

FILE: sim/tb.sv
module tb;
    import lav_pkg::*;

    typedef struct {
        logic [1:0]  col;
        logic [31:0] r0;
        logic [31:0] r1;
        logic [31:0] r2;
        logic        last;
        logic        degen;
    } column_t;

    typedef struct {
        logic [31:0] ex, ey, ez, tx, ty, tz;
        logic        chk;       // typed-in expectation present
        logic        degen_exp; // expected degenerate flag
        logic        zero_exp;  // all values zero expected
    } view_row_t;

    logic            clk;
    logic            rst_n;
    logic            item_valid;
    logic            item_ready;
    coord_t          eye_x, eye_y, eye_z;
    coord_t          target_x, target_y, target_z;
    logic            column_valid;
    logic            column_ready;
    logic [1:0]      column_index;
    coord_t          row0_value, row1_value, row2_value;
    logic            last_column;
    logic            degenerate;

    column_t   pending_cols[$];
    view_row_t dir_rows[$];
    int        errors;
    bit        drained;

    look_at_view_matrix u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .eye_x        (eye_x),
        .eye_y        (eye_y),
        .eye_z        (eye_z),
        .target_x     (target_x),
        .target_y     (target_y),
        .target_z     (target_z),
        .column_valid (column_valid),
        .column_ready (column_ready),
        .column_index (column_index),
        .row0_value   (row0_value),
        .row1_value   (row1_value),
        .row2_value   (row2_value),
        .last_column  (last_column),
        .degenerate   (degenerate)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // ---------------- fixed-point helpers ----------------
    function automatic logic [63:0] abs128_lo(input logic signed [127:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [127:0] rnd_shift(input logic signed [127:0] v,
                                                      input int s);
        logic [127:0] m;
        m = v < 0 ? -v : v;
        m = (m + (128'd1 << (s - 1))) >> s;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // normalize a squared length: returns the root and the shift count
    function automatic logic [63:0] norm_root(input logic [63:0] v2, output int k);
        k = 0;
        while (k < 31 && v2[63:62] == 2'b00)
        begin
            v2 = v2 << 2;
            k++;
        end
        return int_sqrt(v2);
    endfunction

    function automatic logic signed [127:0] unit_comp(input logic signed [127:0] c,
                                                      input logic [63:0] s, input int k);
        logic [127:0] m, q;
        m = c < 0 ? -c : c;
        q = ((m << (30 + k)) + (s >> 1)) / s;
        return c < 0 ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [31:0] clamp32(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'h7fffffff;
        if (v < -128'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    // Build the four expected columns of the view matrix for one item
    task automatic predict_view(input view_row_t it);
        logic signed [127:0] e[3], d[3], f[3], r[3], u[3], val[4][3];
        logic [63:0] m[3], big, h2, l2, sh, sl;
        int kh, kl;
        bit dg;
        column_t c;
        e[0] = $signed(it.ex); e[1] = $signed(it.ey); e[2] = $signed(it.ez);
        d[0] = $signed(it.tx) - e[0];
        d[1] = $signed(it.ty) - e[1];
        d[2] = $signed(it.tz) - e[2];
        dg = (d[0] == 0 && d[1] == 0);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 3; j++) val[i][j] = 0;
        if (!dg)
        begin
            big = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = abs128_lo(d[i]);
                if (m[i] > big) big = m[i];
            end
            if (big >= (64'd1 << 31))
                for (int i = 0; i < 3; i++)
                begin
                    m[i] = (m[i] + 1) >> 1;
                    d[i] = d[i] < 0 ? -$signed({64'd0, m[i]}) : $signed({64'd0, m[i]});
                end
            h2 = m[0] * m[0] + m[1] * m[1];
            l2 = h2 + m[2] * m[2];
            sh = norm_root(h2, kh);
            sl = norm_root(l2, kl);
            for (int i = 0; i < 3; i++) f[i] = unit_comp(d[i], sl, kl);
            r[0] = unit_comp(d[1], sh, kh);
            r[1] = unit_comp(-d[0], sh, kh);
            r[2] = 0;
            u[0] = rnd_shift(r[1] * f[2], 30);
            u[1] = rnd_shift(-(r[0] * f[2]), 30);
            u[2] = rnd_shift(r[0] * f[1] - r[1] * f[0], 30);
            for (int i = 0; i < 3; i++)
            begin
                val[i][0] = rnd_shift(r[i], 14);
                val[i][1] = rnd_shift(u[i], 14);
                val[i][2] = rnd_shift(-f[i], 14);
            end
            val[3][0] = clamp32(rnd_shift(-(r[0] * e[0] + r[1] * e[1]), 30));
            val[3][1] = clamp32(rnd_shift(-(u[0] * e[0] + u[1] * e[1] + u[2] * e[2]), 30));
            val[3][2] = clamp32(rnd_shift(f[0] * e[0] + f[1] * e[1] + f[2] * e[2], 30));
        end
        if (it.chk && (dg != it.degen_exp))
            report_mismatch("directed degenerate case misclassified");
        for (int i = 0; i < 4; i++)
        begin
            c.col   = 2'(i);
            c.r0    = val[i][0][31:0];
            c.r1    = val[i][1][31:0];
            c.r2    = val[i][2][31:0];
            c.last  = (i == 3);
            c.degen = it.chk ? it.degen_exp : dg;
            if (it.chk && it.zero_exp)
            begin
                c.r0 = 0; c.r1 = 0; c.r2 = 0;
            end
            pending_cols.push_back(c);
        end
    endtask

    // ---------------- column checker and receiver stalls ----------------
    int stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_ready <= 1'b0;
            stall_mode   <= 0;
        end
        else
        begin
            if (column_valid && column_ready)
            begin
                column_t x;
                if (pending_cols.size() == 0)
                    report_mismatch("column transfer with nothing expected");
                else
                begin
                    x = pending_cols.pop_front();
                    if (column_index !== x.col)
                        report_mismatch($sformatf("column_index %0d exp %0d",
                                                  column_index, x.col));
                    if (row0_value !== x.r0)
                        report_mismatch($sformatf("col %0d row0 %h exp %h",
                                                  x.col, row0_value, x.r0));
                    if (row1_value !== x.r1)
                        report_mismatch($sformatf("col %0d row1 %h exp %h",
                                                  x.col, row1_value, x.r1));
                    if (row2_value !== x.r2)
                        report_mismatch($sformatf("col %0d row2 %h exp %h",
                                                  x.col, row2_value, x.r2));
                    if (last_column !== x.last)
                        report_mismatch($sformatf("col %0d last_column %b", x.col, last_column));
                    if (degenerate !== x.degen)
                        report_mismatch($sformatf("col %0d degenerate %b", x.col, degenerate));
                end
            end
            // stall pattern: phases of always-ready, random, and long holds
            if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: column_ready <= 1'b1;
                1: column_ready <= ($urandom_range(0, 3) != 0);
                default: column_ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // ---------------- stimulus ----------------
    function automatic view_row_t mk(input logic [31:0] ex, ey, ez, tx, ty, tz,
                                     input logic chk, dexp, zexp);
        view_row_t r;
        r.ex = ex; r.ey = ey; r.ez = ez;
        r.tx = tx; r.ty = ty; r.tz = tz;
        r.chk = chk; r.degen_exp = dexp; r.zero_exp = zexp;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_view(input view_row_t it);
        item_valid <= 1'b1;
        eye_x <= it.ex; eye_y <= it.ey; eye_z <= it.ez;
        target_x <= it.tx; target_y <= it.ty; target_z <= it.tz;
        @(posedge clk);
        while (!item_ready) @(posedge clk);
        predict_view(it);
    endtask

    task automatic idle_cycles(input int n);
        item_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    initial
    begin
        view_row_t it;
        int burst;
        errors       = 0;
        drained      = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        eye_x = 0; eye_y = 0; eye_z = 0;
        target_x = 0; target_y = 0; target_z = 0;

        // directed table: typed expectations only for degenerate rows
        dir_rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 1, 1));
        dir_rows.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h7fffffff, 32'h80000000, 32'h7fffffff, 1, 1, 1));
        dir_rows.push_back(mk(5, 7, 0, 5, 7, 32'h7fffffff, 1, 1, 1));
        dir_rows.push_back(mk(5, 7, 32'h7fffffff, 5, 7, 32'h80000000, 1, 1, 1));
        dir_rows.push_back(mk(0, 0, 0, 32'h00010000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, 0, 0, 32'h00010000, 0, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, 0, 32'hffff0000, 32'hffff0000, 32'h00010000, 0, 0, 0));
        dir_rows.push_back(mk(0, 0, 0, 1, 0, 32'h7fffffff, 0, 0, 0));
        dir_rows.push_back(mk(32'h80000000, 32'h80000000, 32'h80000000,
                              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));
        dir_rows.push_back(mk(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                              32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0));
        dir_rows.push_back(mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h7ffffffe, 32'h7fffffff, 32'h7fffffff, 0, 0, 0));
        dir_rows.push_back(mk(32'h80000000, 32'h7fffffff, 32'h80000000,
                              32'h80000000, 32'h80000001, 0, 0, 0, 0));
        dir_rows.push_back(mk(32'h12345678, 32'hfedcba98, 32'h0badf00d,
                              32'h00000001, 32'hffffffff, 32'h00000000, 0, 0, 0));
        dir_rows.push_back(mk(32'hffffffff, 32'hffffffff, 32'hffffffff,
                              0, 0, 0, 0, 0, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) send_view(dir_rows[i]);

        // random bursts with gaps
        for (int n = 0; n < 160; )
        begin
            burst = $urandom_range(1, 6);
            for (int b = 0; b < burst && n < 160; b++, n++)
            begin
                it = mk(rand_coord(), rand_coord(), rand_coord(),
                        rand_coord(), rand_coord(), rand_coord(), 0, 0, 0);
                // some degenerate views: same x/y, random z
                if ($urandom_range(0, 9) == 0)
                begin
                    it.tx = it.ex; it.ty = it.ey;
                end
                send_view(it);
            end
            if (n >= 80 && !drained)
            begin
                // drain everything before continuing
                drained = 1;
                item_valid <= 1'b0;
                while (pending_cols.size() != 0) @(posedge clk);
            end
            else if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 400));
        end
        item_valid <= 1'b0;
        while (pending_cols.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("[look_at_view_matrix] OK");
        else
            $display("[look_at_view_matrix] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("[look_at_view_matrix] ERROR");
        $finish;
    end

endmodule
